// File: src/fractional_clock_divider_calc_assert.svh
// Assertion macros for the fractional clock divider calculator.
// Included by the top level; no other dependencies.
`ifndef FRACTIONAL_CLOCK_DIVIDER_CALC_ASSERT_SVH
`define FRACTIONAL_CLOCK_DIVIDER_CALC_ASSERT_SVH
`ifndef SYNTHESIS
`define FCD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FCD_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCD_ASSERT(lbl, clk, rst, prop, msg)
`define FCD_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// File: src/fcd_pkg.sv
// Shared types and constants for the fractional clock divider calculator.
// No dependencies.
`default_nettype none
package fcd_pkg;
   localparam int unsigned FracBitsDefault  = 24;
   localparam int unsigned MultLimitDefault = 64;
   localparam logic [31:0] SourceResetHz    = 32'd40000000;
   localparam int unsigned IntPos  = 12;
   localparam int unsigned NumPos  = 6;

   // front-to-back queue entry
   typedef struct packed {
      logic        err;
      logic [7:0]  quot_m1;
      logic [31:0] rem;
      logic [31:0] target;
   } job_type;

   typedef struct packed {
      logic [7:0] quot_m1;
      logic [5:0] mult;
      logic [5:0] num;
      logic       err;
   } res_type;
endpackage
`default_nettype wire

// File: src/fcd_front.sv
// Front end: divides source by target (restoring, one bit a cycle), range checks.
// Depends on fcd_pkg.
`default_nettype none
module fcd_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [31:0]     source,
   input  wire logic            in_valid,
   input  wire logic [31:0]     in_target,
   output logic                 in_ready,
   output logic                 out_valid,
   output fcd_pkg::job_type     out_job,
   input  wire logic            out_ready
);
   import fcd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] tgt_ff, tgt_in;
   logic [31:0] dvd_ff, dvd_in;   // shifts out into quotient
   logic [32:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] trial;
   logic        ge;

   assign trial = {rem_ff[31:0], dvd_ff[31]};
   assign ge    = trial >= {1'b0, tgt_ff};

   always_comb begin
      state_in = state_ff;
      tgt_in   = tgt_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               tgt_in   = in_target;
               dvd_in   = source;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = ge ? trial - {1'b0, tgt_ff} : trial;
            dvd_in = {dvd_ff[30:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
      tgt_ff <= tgt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign in_ready  = state_ff == ST_IDLE;
   assign out_valid = state_ff == ST_DONE;
   always_comb begin
      out_job.target  = tgt_ff;
      out_job.rem     = rem_ff[31:0];
      out_job.quot_m1 = 8'(dvd_ff - 32'd1);
      out_job.err     = (tgt_ff == '0) || (dvd_ff == '0) || (dvd_ff > 32'd256);
   end
endmodule
`default_nettype wire

// File: src/fcd_back.sv
// Back end: fraction by long division, then each multiplier tried in turn.
// Depends on fcd_pkg.
`default_nettype none
module fcd_back #(
   parameter int unsigned FRAC_BITS  = fcd_pkg::FracBitsDefault,
   parameter int unsigned MULT_LIMIT = fcd_pkg::MultLimitDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  fcd_pkg::job_type   in_job,
   output logic               in_ready,
   output logic               out_valid,
   output fcd_pkg::res_type   out_res,
   input  wire logic          out_ready
);
   import fcd_pkg::*;

   localparam int unsigned NW = FRAC_BITS + 6;   // fraction*m width
   localparam int unsigned EW = FRAC_BITS + 7;   // rebuild dividend width

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FRAC  = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_RDIV  = 6'b001000,
      ST_CMP   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   logic [32:0]        r_ff, r_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [6:0]         m_ff, m_in;
   logic [5:0]         num_ff, num_in;
   logic [EW-1:0]      dq_ff, dq_in;      // rebuild dividend -> quotient
   logic [6:0]         rr_ff, rr_in;      // rebuild remainder
   logic [FRAC_BITS:0] best_err_ff, best_err_in;
   logic [5:0]         best_m_ff, best_m_in, best_n_ff, best_n_in;
   logic               first_ff, first_in;
   logic [33:0]        ftrial;
   logic [NW-1:0]      prod;
   logic [7:0]         rtrial;
   logic               rge;
   logic [EW-1:0]      rebuilt;
   logic [FRAC_BITS:0] err;

   assign ftrial  = {r_ff, 1'b0};
   assign prod    = NW'(frac_ff) * NW'(m_ff);
   assign rtrial  = {rr_ff, dq_ff[EW-1]};
   assign rge     = rtrial >= {1'b0, m_ff};
   assign rebuilt = dq_ff;
   assign err     = (rebuilt >= EW'(frac_ff))
                    ? (FRAC_BITS+1)'(rebuilt - EW'(frac_ff))
                    : (FRAC_BITS+1)'(EW'(frac_ff) - rebuilt);

   always_comb begin
      state_in = state_ff; job_in = job_ff; r_in = r_ff; frac_in = frac_ff;
      cnt_in = cnt_ff; m_in = m_ff; num_in = num_ff; dq_in = dq_ff;
      rr_in = rr_ff; best_err_in = best_err_ff; best_m_in = best_m_ff;
      best_n_in = best_n_ff; first_in = first_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               job_in   = in_job;
               r_in     = {1'b0, in_job.rem};
               cnt_in   = '0;
               state_in = in_job.err ? ST_DONE : ST_FRAC;
            end
         end
         ST_FRAC: begin
            // (rem << FRAC_BITS) / target, one bit a beat
            if (ftrial >= {2'b0, job_ff.target}) begin
               r_in    = 33'(ftrial - {2'b0, job_ff.target});
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               r_in    = ftrial[32:0];
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(FRAC_BITS-1)) begin
               m_in = 7'd2; first_in = 1'b1; state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            num_in   = prod[NW-1:FRAC_BITS];
            dq_in    = EW'(prod[NW-1:FRAC_BITS]) << FRAC_BITS;
            rr_in    = '0;
            cnt_in   = '0;
            state_in = ST_RDIV;
         end
         ST_RDIV: begin
            rr_in = rge ? 7'(rtrial - {1'b0, m_ff}) : rtrial[6:0];
            dq_in = {dq_ff[EW-2:0], rge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(EW-1)) state_in = ST_CMP;
         end
         ST_CMP: begin
            if (first_ff || err < best_err_ff) begin
               best_err_in = err; best_m_in = m_ff[5:0]; best_n_in = num_ff;
            end
            first_in = 1'b0;
            m_in     = m_ff + 7'd1;
            state_in = (m_ff == 7'(MULT_LIMIT-1)) ? ST_DONE : ST_MUL;
         end
         ST_DONE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
      job_ff <= job_in; r_ff <= r_in; frac_ff <= frac_in; cnt_ff <= cnt_in;
      m_ff <= m_in; num_ff <= num_in; dq_ff <= dq_in; rr_ff <= rr_in;
      best_err_ff <= best_err_in; best_m_ff <= best_m_in; best_n_ff <= best_n_in;
      first_ff <= first_in;
   end

   assign in_ready  = state_ff == ST_IDLE;
   assign out_valid = state_ff == ST_DONE;
   always_comb begin
      out_res.err     = job_ff.err;
      out_res.quot_m1 = job_ff.err ? '0 : job_ff.quot_m1;
      out_res.mult    = job_ff.err ? '0 : best_m_ff;
      out_res.num     = job_ff.err ? '0 : best_n_ff;
   end
endmodule
`default_nettype wire

// File: src/fcd_queue.sv
// Two-entry result/job queue with registered outputs.
// No dependencies; the payload width is set by W.
`default_nettype none
module fcd_queue #(
   parameter int unsigned W = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         wr_valid,
   input  wire logic [W-1:0] wr_data,
   output logic              wr_ready,
   output logic              rd_valid,
   output logic [W-1:0]      rd_data,
   input  wire logic         rd_ready
);
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         wr, rd;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= 2'(cnt_ff + {1'b0, wr} - {1'b0, rd});
      end
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule
`default_nettype wire

// File: src/fractional_clock_divider_calc.sv
// Fractional clock divider calculator, top level.
// Channels: req_ (push/full) carries the wanted output frequency; rsp_ (empty/pop)
// carries the divider setting; csr_ writes source_clock_hz (reset value 40 MHz).
// The front end divides source by target, one quotient bit per cycle, and
// takes a new request only after handing the last one on. A two-entry queue
// hands the quotient and remainder to the back end, which forms the fraction
// and then tries each multiplier 2..MULT_LIMIT-1 in turn: multiply, restoring
// rebuild divide, compare. The back end sets the throughput. Range errors
// skip the search; for those the front end sets the rate.
// full is high whenever the front end is busy. Results land in a two-entry
// output queue; a stalled receiver fills it, then the back end, the job queue
// and the front end hold in turn. Reset empties all queues and returns both
// ends to idle.
// Requires: fcd_pkg, fcd_front, fcd_back, fcd_queue, assertion header.
`default_nettype none
`include "fractional_clock_divider_calc_assert.svh"
module fractional_clock_divider_calc #(
   parameter int unsigned FRAC_BITS  = fcd_pkg::FracBitsDefault,
   parameter int unsigned MULT_LIMIT = fcd_pkg::MultLimitDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [31:0] req_target_hz,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_div_integral_minus_one,
   output logic [5:0]       rsp_frac_multiplier,
   output logic [5:0]       rsp_frac_numerator,
   output logic [19:0]      rsp_divider_word,
   output logic             rsp_range_error,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);
   import fcd_pkg::*;

   logic [31:0] src_ff;
   logic        f_ready, f_valid, q_valid, q_ready, b_valid, b_ready, o_valid;
   logic        q_ready_w;
   job_type     f_job, q_job;
   res_type     b_res, o_res;

   always_ff @(posedge clock) begin
      if (reset)          src_ff <= SourceResetHz;
      else if (csr_wr_en) src_ff <= csr_wr_data;
   end

   fcd_front u_front (
      .clock, .reset, .source(src_ff), .in_valid(push), .in_target(req_target_hz),
      .in_ready(f_ready), .out_valid(f_valid), .out_job(f_job), .out_ready(q_ready_w)
   );

   fcd_queue #(.W($bits(job_type))) u_jobq (
      .clock, .reset, .wr_valid(f_valid), .wr_data(f_job), .wr_ready(q_ready_w),
      .rd_valid(q_valid), .rd_data(q_job), .rd_ready(q_ready)
   );

   fcd_back #(.FRAC_BITS(FRAC_BITS), .MULT_LIMIT(MULT_LIMIT)) u_back (
      .clock, .reset, .in_valid(q_valid), .in_job(q_job), .in_ready(q_ready),
      .out_valid(b_valid), .out_res(b_res), .out_ready(b_ready)
   );

   fcd_queue #(.W($bits(res_type))) u_rspq (
      .clock, .reset, .wr_valid(b_valid), .wr_data(b_res), .wr_ready(b_ready),
      .rd_valid(o_valid), .rd_data(o_res), .rd_ready(pop)
   );

   assign full  = !f_ready;
   assign empty = !o_valid;
   assign rsp_range_error            = o_res.err;
   assign rsp_div_integral_minus_one = o_res.quot_m1;
   assign rsp_frac_multiplier        = o_res.mult;
   assign rsp_frac_numerator         = o_res.num;
   assign rsp_divider_word = {o_res.quot_m1, o_res.num, o_res.mult};

   `FCD_ASSERT(a_err_zero, clock, reset, (!empty && rsp_range_error) |-> (rsp_divider_word == '0), "error result carries nonzero fields")
   `FCD_ASSERT(a_mult_range, clock, reset, (!empty && !rsp_range_error) |-> (rsp_frac_multiplier >= 6'd2), "multiplier below two")
   `FCD_ASSERT_RST(a_reset_empty, clock, $past(reset) |-> empty, "result queue not empty after reset")
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for fractional_clock_divider_calc: queue-style request and
// response channels, source clock register, scoreboard class with its own predictor.
// Depends on fcd_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
   import fcd_pkg::*;

   localparam int unsigned FracBits  = FracBitsDefault;
   localparam int unsigned MultLimit = MultLimitDefault;
   localparam int unsigned CfgSource = 0;
   localparam longint unsigned CycleLimit = 30_000_000;

   typedef struct packed {
      logic [7:0]  quot_m1;
      logic [5:0]  mult;
      logic [5:0]  num;
      logic [19:0] word;
      logic        err;
   } setting_type;

   class divider_scoreboard;
      setting_type pending[$];
      logic [31:0] src_freq = SourceResetHz;
      int          mismatches = 0;
      int          matched = 0;
      int          range_errs = 0;
      int          exact_hits = 0;

      function automatic setting_type work_out(logic [31:0] target);
         setting_type s;
         longint unsigned quot, fraction, num, rebuilt, diff, best_diff;
         longint unsigned best_m, best_n;
         s = '0;
         s.err = 1'b1;
         if (target == 0) return s;
         quot = longint'(src_freq) / longint'(target);
         if (quot < 1 || quot > 256) return s;
         fraction = ((longint'(src_freq) % longint'(target)) << FracBits)
                    / longint'(target);
         if (fraction == 0) exact_hits++;
         best_diff = '1;
         best_m = 2;
         best_n = 0;
         for (longint unsigned m = 2; m < MultLimit; m++) begin
            num = (fraction * m) >> FracBits;
            rebuilt = (num << FracBits) / m;
            diff = (rebuilt >= fraction) ? rebuilt - fraction : fraction - rebuilt;
            if (diff < best_diff) begin
               best_diff = diff;
               best_m = m;
               best_n = num;
            end
         end
         s.err = 1'b0;
         s.quot_m1 = 8'(quot - 1);
         s.mult = 6'(best_m);
         s.num = 6'(best_n);
         s.word = {s.quot_m1, s.num, s.mult};
         return s;
      endfunction

      function void note_request(logic [31:0] target);
         pending.push_back(work_out(target));
      endfunction

      function void check_setting(setting_type got);
         setting_type exp;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected beat %h with nothing outstanding", got);
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: q-1 %0d/%0d mult %0d/%0d num %0d/%0d word %h/%h err %b/%b",
                        exp.quot_m1, got.quot_m1, exp.mult, got.mult, exp.num, got.num,
                        exp.word, got.word, exp.err, got.err);
         end else begin
            matched++;
            if (got.err) range_errs++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [31:0] req_target_hz = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_div_integral_minus_one;
   logic [5:0]  rsp_frac_multiplier;
   logic [5:0]  rsp_frac_numerator;
   logic [19:0] rsp_divider_word;
   logic        rsp_range_error;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   divider_scoreboard sb = new();
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_request = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   int sent = 0;
   longint unsigned cycles = 0;

   fractional_clock_divider_calc dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_target_hz(req_target_hz),
      .empty(empty), .pop(pop),
      .rsp_div_integral_minus_one(rsp_div_integral_minus_one),
      .rsp_frac_multiplier(rsp_frac_multiplier),
      .rsp_frac_numerator(rsp_frac_numerator),
      .rsp_divider_word(rsp_divider_word),
      .rsp_range_error(rsp_range_error),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (push && full) stall_cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("** fractional_clock_divider_calc: FAILED **");
         $finish;
      end
   end

   // response beats
   always @(posedge clock) begin
      if (!reset && pop && !empty)
         sb.check_setting({rsp_div_integral_minus_one, rsp_frac_multiplier,
                           rsp_frac_numerator, rsp_divider_word, rsp_range_error});
   end

   // receiver, with its own long hold-off counter
   always @(negedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = 600;
      end
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   task automatic send_target(logic [31:0] target);
      bit taken;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push <= 1'b1;
      req_target_hz <= target;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         taken = !full;
      end
      sb.note_request(target);
      sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      push <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_source(logic [31:0] hz);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= hz;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.src_freq = hz;
   endtask

   function automatic logic [31:0] pick_target(logic [31:0] src);
      logic [31:0] lo;
      if ($urandom_range(0, 99) < 20) return $urandom();
      if ($urandom_range(0, 99) < 5) return 32'($urandom_range(0, 2));
      lo = (src >> 8) == 0 ? 32'd1 : src >> 8;
      if ($urandom_range(0, 99) < 10) return src / 32'($urandom_range(1, 256));
      return $urandom_range(lo, src);
   endfunction

   initial begin
      logic [31:0] sources[6];
      int per_phase;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset source frequency
      foreach (sources[i]) sources[i] = 0;
      send_target(32'd0);
      send_target(32'd1);
      send_target(32'hFFFF_FFFF);
      send_target(SourceResetHz);
      send_target(SourceResetHz + 1);
      send_target(SourceResetHz / 256);
      send_target(SourceResetHz / 256 - 1);
      send_target(SourceResetHz / 3);
      send_target(32'd1_000_000);
      send_target(32'd3_000_000);
      send_target(32'd7_000_001);
      send_target(32'h5555_5555 >> 12);
      send_target(32'hAAAA_AAAA >> 12);
      drain_results();

      // fill the block with fast range-error requests against a stalled receiver
      hold_request++;
      for (int i = 0; i < 12; i++) send_target(32'd0);
      drain_results();

      write_source(32'hFFFF_FFFF);
      send_target(32'hFFFF_FFFF);
      send_target(32'h00FF_FFFF);
      send_target(32'h0100_0000);
      send_target(32'h8000_0000);
      drain_results();
      write_source(32'd1);
      send_target(32'd1);
      send_target(32'd2);
      drain_results();
      write_source(32'd0);
      send_target(32'd1);
      send_target(32'd0);
      drain_results();

      sources[0] = 32'hFFFF_FFFF;
      sources[1] = SourceResetHz;
      sources[2] = 32'd0;
      sources[3] = $urandom();
      sources[4] = 32'd1;
      sources[5] = $urandom_range(1000, 100_000_000);
      per_phase = 1700 / 6;
      for (int ph = 0; ph < 6; ph++) begin
         write_source(sources[ph]);
         case (ph % 3)
            0: begin tx_idle_pct = 29; rx_idle_pct = 88; end
            1: begin tx_idle_pct = 88; rx_idle_pct = 29; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         if (ph == 3) hold_request++;
         for (int i = 0; i < per_phase; i++) send_target(pick_target(sources[ph]));
         drain_results();
      end
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_source(SourceResetHz);

      repeat (2000) @(posedge clock);
      $display("%0d requests over %0d source settings, %0d range errors, %0d exact ratios",
               sent, 10, sb.range_errs, sb.exact_hits);
      $display("%0d cycles with input stalled, %0d cycles in all", stall_cycles, cycles);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("** fractional_clock_divider_calc: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
         $display("** fractional_clock_divider_calc: FAILED **");
      end
      $finish;
   end
endmodule
